// ===== rtl/core/heron_integer_square_root_core_defines.svh =====
// Assertion macros shared by the Heron square root RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef HERON_INTEGER_SQUARE_ROOT_CORE_DEFINES_SVH
`define HERON_INTEGER_SQUARE_ROOT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define HISR_ASSERT_IMPLIES(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("Same-cycle implication failed.");

// Next-cycle implication, checked outside of reset.
`define HISR_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("Next-cycle implication failed.");

`endif

// ===== rtl/core/hisr_pkg.sv =====
// Package for the Heron integer square root core: widths, step limit, sequencer
// states and the divider status bundle. No dependencies.
package hisr_pkg;

    localparam int ValueWidth = 16;
    localparam int RootWidth  = 9;
    localparam int StepWidth  = 5;
    localparam int CountWidth = 4;

    // Safety bound on Newton steps, as a step index limit.
    localparam logic [StepWidth-1:0] LastStep = 5'd31;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_FIN
    } hisr_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } hisr_div_status_t;

endpackage

// ===== rtl/core/hisr_div.sv =====
// Restoring radix-2 divider for 16-bit unsigned operands, one quotient bit per cycle.
// Depends on hisr_pkg. The divisor must be nonzero.
module hisr_div
    import hisr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [ValueWidth-1:0] dividend,
    input  logic [ValueWidth-1:0] divisor,
    output logic [ValueWidth-1:0] quotient,
    output hisr_div_status_t      status
);

    logic [ValueWidth:0]     rem_reg, rem_next;
    logic [ValueWidth-1:0]   quo_reg, quo_next;
    logic [ValueWidth-1:0]   dvs_reg, dvs_next;
    logic [CountWidth-1:0]   cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [ValueWidth:0]     shifted;
    logic [ValueWidth:0]     trial;
    logic                    fits;

    // One trial subtraction of the divisor from the shifted partial remainder.
    assign shifted = {rem_reg[ValueWidth-1:0], quo_reg[ValueWidth-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    // Next-state logic for the iteration.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '1;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial : shifted;
            quo_next = {quo_reg[ValueWidth-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/core/heron_integer_square_root_core.sv =====
// Top level of the Heron integer square root core.
// Depends on hisr_pkg, hisr_div and heron_integer_square_root_core_defines.svh.
//
// Takes one unsigned 16-bit word and returns its Heron (Newton) square root,
// which may exceed the floor root by one. The guess starts at the value and
// each step forms (guess + value / guess) / 2 until the guess moves by at most
// one. Each step starts the shared bit-serial divider, waits for its quotient
// bits and then updates the guess. After the last step the finish state waits
// until the output register is free, loads the root into it and returns to
// idle, where the input side is ready again; a zero input skips the divider
// and goes straight to the finish state. The input side accepts a new word
// only when the previous item has finished and its result is in the output
// register, which may still be waiting for the consumer.
`include "heron_integer_square_root_core_defines.svh"

module heron_integer_square_root_core
    import hisr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [8:0] root, [15:9] zero
);

    hisr_state_t             state_reg, state_next;
    logic [ValueWidth-1:0]   value_reg, value_next;
    logic [ValueWidth-1:0]   guess_reg, guess_next;
    logic [StepWidth-1:0]    step_reg, step_next;
    logic [RootWidth-1:0]    root_reg, root_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    in_accept;
    logic                    out_free;
    logic                    div_start;
    logic [ValueWidth-1:0]   quotient;
    hisr_div_status_t        div_status;
    logic [ValueWidth:0]     sum;
    logic [ValueWidth-1:0]   halved;
    logic [ValueWidth-1:0]   new_guess;
    logic [ValueWidth-1:0]   diff;
    logic                    settled;

    // Shared divider: value / guess.
    hisr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (value_reg),
        .divisor  (guess_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    // Newton update and stopping test.
    assign sum       = {1'b0, guess_reg} + {1'b0, quotient};
    assign halved    = sum[ValueWidth:1];
    assign new_guess = (halved == '0) ? {{(ValueWidth-1){1'b0}}, 1'b1} : halved;
    assign diff      = guess_reg - new_guess;
    assign settled   = (diff <= {{(ValueWidth-1){1'b0}}, 1'b1}) || (step_reg == LastStep);

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (s_axis_tdata == '0) ? S_FIN : S_START;
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = settled ? S_FIN : S_START;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs and datapath updates.
    always_comb
    begin
        s_axis_tready  = 1'b0;
        div_start      = 1'b0;
        value_next     = value_reg;
        guess_next     = guess_reg;
        step_next      = step_reg;
        root_next      = root_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_accept)
                begin
                    value_next = s_axis_tdata;
                    guess_next = s_axis_tdata;
                    step_next  = '0;
                end
            end
            S_START:
            begin
                div_start = 1'b1;
            end
            S_WAIT:
            begin
                if (div_status.done)
                begin
                    guess_next = new_guess;
                    step_next  = step_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    root_next      = guess_reg[RootWidth-1:0];
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        guess_reg <= guess_next;
        root_reg  <= root_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16-RootWidth){1'b0}}, root_reg};

    // Design checks.
    `HISR_ASSERT_IMPLIES(a_done_only_waiting, div_status.done, state_reg == S_WAIT)
    `HISR_ASSERT_IMPLIES(a_start_when_free, state_reg == S_START, !div_status.busy)
    `HISR_ASSERT_IMPLIES(a_root_in_range, state_reg == S_FIN, guess_reg <= 16'd256)
    `HISR_ASSERT_NEXT(a_nonzero_iterates, in_accept && (s_axis_tdata != 16'd0),
        state_reg == S_START)

endmodule
